@@ rtl/core/bsos_pkg.sv @@
// shared types and constants of the box surface overlap scan
package bsos_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int SLOT_W = 8;
	localparam int CNT_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
	localparam int CRD_W = 32;
	localparam int IN_DATA_W = 208;
	localparam int OUT_DATA_W = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [3:0] SURF_TYPE_TESTED = 4'd3;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_PRESENT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_EXT = 3'd5;

	// input tdata layout, first member is the top bits
	typedef struct packed {
		logic pad;
		logic [CRD_W-1:0] coord_f;
		logic [CRD_W-1:0] coord_e;
		logic [CRD_W-1:0] coord_d;
		logic [CRD_W-1:0] coord_c;
		logic [CRD_W-1:0] coord_b;
		logic [CRD_W-1:0] coord_a;
		logic flag_b;
		logic flag_a;
		logic [3:0] surface_kind;
		logic end_mark;
		logic [SLOT_W-1:0] slot;
	} in_data_t;

	typedef struct packed {
		logic end_mark;
		logic [3:0] surface_kind;
		logic flag_a;
		logic flag_b;
		logic [CRD_W-1:0] min_x;
		logic [CRD_W-1:0] min_y;
		logic [CRD_W-1:0] max_x;
		logic [CRD_W-1:0] max_y;
		logic [CRD_W-1:0] z_top;
		logic [CRD_W-1:0] z_bottom;
	} entry_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] bx0;
		logic signed [CRD_W-1:0] bx1;
		logic signed [CRD_W-1:0] by0;
		logic signed [CRD_W-1:0] by1;
		logic signed [CRD_W-1:0] z;
		logic signed [CRD_W-1:0] zh;
		logic signed [CRD_W-1:0] limit;
	} box_t;

	typedef struct packed {
		logic stop;
		logic hit;
	} verdict_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		STEP_BX0,
		STEP_BX1,
		STEP_BY0,
		STEP_BY1,
		STEP_ZH
	} setup_step_t;

endpackage

@@ rtl/core/box_surface_overlap_scan.sv @@
// top level: configuration, sequencer, shared box adder and scan loop
// write transaction: taken while idle, no result
// query transaction: accept, box setup on the shared adder (bx0, bx1, by0, by1, zh), then a scan
//   with one table read per cycle, then the output register; with present clear, setup and scan are skipped
// one item at a time; a new item is taken while a finished result waits at the output
// reset clears control state and configuration; table contents undefined until written
module box_surface_overlap_scan
	import bsos_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // slot, end_mark, surface_kind, flag_a, flag_b,
	                                        // coord_a..coord_f, zero pad
	input  logic                  s_tuser,  // kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // clear, zero pad
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CRD_W-1:0]      cfg_data
);

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	in_data_t in_d;
	entry_t wr_entry, rd_entry;
	box_t box_q;
	verdict_t verdict;
	state_t state_q, state_d;
	setup_step_t step_q, step_d;

	logic present_q;
	logic [CRD_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q, vext_q;
	logic [CRD_W-1:0] px_q, py_q;
	logic [CNT_W-1:0] ptr_q, ptr_d, slot_ext;
	logic pend_s1;
	logic rd_en, wr_en, in_acc;
	logic res_q, res_d;
	logic m_tvalid_q, clear_q;
	logic load_out;
	logic [CRD_W-1:0] add_a, add_b, add_sum;

	assign in_d = in_data_t'(s_tdata);
	assign slot_ext = CNT_W'(in_d.slot);
	assign in_acc = s_tvalid && s_tready;
	assign wr_en = in_acc && (s_tuser == KIND_WRITE) && (slot_ext < DEPTH_C);

	assign wr_entry.end_mark = in_d.end_mark;
	assign wr_entry.surface_kind = in_d.surface_kind;
	assign wr_entry.flag_a = in_d.flag_a;
	assign wr_entry.flag_b = in_d.flag_b;
	assign wr_entry.min_x = in_d.coord_a;
	assign wr_entry.min_y = in_d.coord_b;
	assign wr_entry.z_top = in_d.coord_c;
	assign wr_entry.z_bottom = in_d.coord_d;
	assign wr_entry.max_x = in_d.coord_e;
	assign wr_entry.max_y = in_d.coord_f;

	bsos_table u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (slot_ext[IDX_W-1:0]),
		.wr_entry (wr_entry),
		.rd_en    (rd_en),
		.rd_addr  (ptr_q[IDX_W-1:0]),
		.rd_entry (rd_entry)
	);

	bsos_test u_test (
		.entry   (rd_entry),
		.box     (box_q),
		.verdict (verdict)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			min_x_q <= '0;
			max_x_q <= '0;
			min_y_q <= '0;
			max_y_q <= '0;
			vext_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRESENT:   present_q <= cfg_data[0];
				REG_BOX_MIN_X: min_x_q <= cfg_data;
				REG_BOX_MAX_X: max_x_q <= cfg_data;
				REG_BOX_MIN_Y: min_y_q <= cfg_data;
				REG_BOX_MAX_Y: max_y_q <= cfg_data;
				REG_VERT_EXT:  vext_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// shared adder for box setup
	always_comb begin
		unique case (step_q)
			STEP_BX0: begin
				add_a = px_q;
				add_b = min_x_q;
			end
			STEP_BX1: begin
				add_a = px_q;
				add_b = max_x_q;
			end
			STEP_BY0: begin
				add_a = py_q;
				add_b = min_y_q;
			end
			STEP_BY1: begin
				add_a = py_q;
				add_b = max_y_q;
			end
			STEP_ZH: begin
				add_a = box_q.z;
				add_b = vext_q;
			end
			default: begin
				add_a = px_q;
				add_b = min_x_q;
			end
		endcase
		add_sum = add_a + add_b;
	end

	always_ff @(posedge clk) begin
		if (in_acc && (s_tuser == KIND_QUERY)) begin
			px_q <= in_d.coord_a;
			py_q <= in_d.coord_b;
			box_q.z <= $signed(in_d.coord_c);
			box_q.limit <= $signed(in_d.coord_e);
		end
		if (state_q == ST_SETUP) begin
			unique case (step_q)
				STEP_BX0: box_q.bx0 <= $signed(add_sum);
				STEP_BX1: box_q.bx1 <= $signed(add_sum);
				STEP_BY0: box_q.by0 <= $signed(add_sum);
				STEP_BY1: box_q.by1 <= $signed(add_sum);
				STEP_ZH:  box_q.zh <= $signed(add_sum);
				default: ;
			endcase
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		step_d = step_q;
		ptr_d = ptr_q;
		res_d = res_q;
		rd_en = 1'b0;
		load_out = 1'b0;
		s_tready = (state_q == ST_IDLE);

		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (s_tuser == KIND_QUERY)) begin
					ptr_d = slot_ext;
					step_d = STEP_BX0;
					res_d = 1'b1;
					state_d = present_q ? ST_SETUP : ST_EMIT;
				end
			end
			ST_SETUP: begin
				if (step_q == STEP_ZH) begin
					state_d = ST_SCAN;
				end else begin
					step_d = setup_step_t'(step_q + 3'd1);
				end
			end
			ST_SCAN: begin
				if (pend_s1 && verdict.stop) begin
					res_d = 1'b1;
					state_d = ST_EMIT;
				end else if (pend_s1 && verdict.hit) begin
					res_d = 1'b0;
					state_d = ST_EMIT;
				end else if (ptr_q >= DEPTH_C) begin
					res_d = 1'b1;
					state_d = ST_EMIT;
				end else begin
					rd_en = 1'b1;
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= STEP_BX0;
			ptr_q <= '0;
			pend_s1 <= 1'b0;
			res_q <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			ptr_q <= ptr_d;
			pend_s1 <= rd_en;
			res_q <= res_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			clear_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {{(OUT_DATA_W-1){1'b0}}, clear_q};

endmodule

@@ rtl/core/bsos_table.sv @@
// surface table memory, one write and one registered read port
module bsos_table
	import bsos_pkg::*;
(
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_entry,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_entry
);

	entry_t mem [TABLE_DEPTH];
	entry_t rd_entry_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry_q <= mem[rd_addr];
		end
	end

	assign rd_entry = rd_entry_q;

endmodule

@@ rtl/core/bsos_test.sv @@
// entry test unit, applied to one table entry per cycle
module bsos_test
	import bsos_pkg::*;
(
	input  entry_t   entry,
	input  box_t     box,
	output verdict_t verdict
);

	logic signed [CRD_W-1:0] sx0, sx1, sy0, sy1, zt, zb;
	logic eligible, contain, edge_x, edge_y, span_x, span_y;

	always_comb begin
		sx0 = $signed(entry.min_x);
		sx1 = $signed(entry.max_x);
		sy0 = $signed(entry.min_y);
		sy1 = $signed(entry.max_y);
		zt = $signed(entry.z_top);
		zb = $signed(entry.z_bottom);

		eligible = (entry.surface_kind == SURF_TYPE_TESTED) && !entry.flag_a && entry.flag_b
			&& (box.z <= zt) && (box.zh >= zb);
		contain = (sx0 <= box.bx0) && (sx1 >= box.bx1) && (sy0 <= box.by0) && (sy1 >= box.by1);
		edge_x = ((sx0 <= box.bx0) && (sx1 > box.bx0)) || ((sx0 < box.bx1) && (sx1 >= box.bx1));
		edge_y = ((sy0 <= box.by0) && (sy1 > box.by0)) || ((sy0 < box.by1) && (sy1 >= box.by1));
		span_x = ((sx0 >= box.bx0) && (sx0 < box.bx1)) || ((sx1 > box.bx0) && (sx1 <= box.bx1));
		span_y = ((sy0 >= box.by0) && (sy0 < box.by1)) || ((sy1 > box.by0) && (sy1 <= box.by1));

		verdict.stop = entry.end_mark || (sx0 >= box.limit);
		verdict.hit = !verdict.stop && eligible
			&& (contain || (edge_x && span_y) || (edge_y && span_x));
	end

endmodule

@@ rtl/core/bsos_check.sv @@
// port-level checker for the box surface overlap scan, bound to the top level
module bsos_check
	import bsos_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	logic s_acc;

	assign s_acc = s_tvalid && s_tready;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a query keeps the block busy in the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_tuser == KIND_QUERY) |=> !s_tready)
		else $error("ready right after a query transaction");

	// a write transaction never makes a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_tuser == KIND_WRITE) && !m_tvalid |=> !m_tvalid)
		else $error("result after a write transaction");

	// result pad bits are zero
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_DATA_W-1:1] == '0))
		else $error("nonzero pad bits in result");

endmodule

bind box_surface_overlap_scan bsos_check u_bsos_check (.*);

@@ tb/sv/box_surface_overlap_scan_tb.sv @@
`timescale 1ns / 100ps
// stream testbench of the box surface overlap scan with a table mirror and an in-order clear check
module box_surface_overlap_scan_tb;
	import bsos_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [CRD_W-1:0] CRD_MIN = 32'h8000_0000;
	localparam logic [CRD_W-1:0] CRD_MAX = 32'h7fff_ffff;

	typedef struct {
		logic kind;
		in_data_t data;
	} scan_item_t;

	typedef struct {
		logic end_mark;
		logic [3:0] surface_kind;
		logic flag_a;
		logic flag_b;
		logic signed [CRD_W-1:0] min_x;
		logic signed [CRD_W-1:0] min_y;
		logic signed [CRD_W-1:0] max_x;
		logic signed [CRD_W-1:0] max_y;
		logic signed [CRD_W-1:0] z_top;
		logic signed [CRD_W-1:0] z_bottom;
	} surface_rec_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;  // slot, end_mark, surface_kind, flag_a, flag_b,
	                                // coord_a..coord_f, zero pad
	logic s_tuser;                  // kind
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata; // clear, zero pad
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CRD_W-1:0] cfg_data;

	scan_item_t pending_items[$];
	logic expected_clear[$];
	surface_rec_t surface_table [TABLE_DEPTH];

	logic present_cfg;
	logic signed [CRD_W-1:0] box_min_x_cfg;
	logic signed [CRD_W-1:0] box_max_x_cfg;
	logic signed [CRD_W-1:0] box_min_y_cfg;
	logic signed [CRD_W-1:0] box_max_y_cfg;
	logic signed [CRD_W-1:0] vert_ext_cfg;

	int error_count;
	int results_seen;
	int gap_left;
	int stall_left;
	logic in_taken;
	logic calm;

	box_surface_overlap_scan i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	function automatic logic crosses_edge(input logic signed [CRD_W-1:0] smin, smax, bmin, bmax);
		return (smin <= bmin && smax > bmin) || (smin < bmax && smax >= bmax);
	endfunction

	function automatic logic within_span(input logic signed [CRD_W-1:0] smin, smax, bmin, bmax);
		return (smin >= bmin && smin < bmax) || (smax > bmin && smax <= bmax);
	endfunction

	function automatic logic predict_clear(input logic [SLOT_W-1:0] start,
			input logic signed [CRD_W-1:0] px, py, pz, limit);
		logic signed [CRD_W-1:0] bx0, bx1, by0, by1, zh;
		surface_rec_t e;
		if (!present_cfg)
			return 1'b1;
		bx0 = px + box_min_x_cfg;
		bx1 = px + box_max_x_cfg;
		by0 = py + box_min_y_cfg;
		by1 = py + box_max_y_cfg;
		zh = pz + vert_ext_cfg;
		for (int i = start; i < TABLE_DEPTH; i++) begin
			e = surface_table[i];
			if (e.end_mark || e.min_x >= limit)
				return 1'b1;
			if (e.surface_kind != SURF_TYPE_TESTED || e.flag_a || !e.flag_b)
				continue;
			if (!(pz <= e.z_top && zh >= e.z_bottom))
				continue;
			if (e.min_x <= bx0 && e.max_x >= bx1 && e.min_y <= by0 && e.max_y >= by1)
				return 1'b0;
			if (crosses_edge(e.min_x, e.max_x, bx0, bx1) && within_span(e.min_y, e.max_y, by0, by1))
				return 1'b0;
			if (crosses_edge(e.min_y, e.max_y, by0, by1) && within_span(e.min_x, e.max_x, bx0, bx1))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [CRD_W-1:0] near_offset(input int r);
		int v;
		v = $urandom_range(0, 2 * r);
		return v - r;
	endfunction

	function automatic logic [CRD_W-1:0] pick_coord(input int r);
		case ($urandom_range(0, 15))
			0: return $urandom();
			1: return CRD_MIN;
			2: return CRD_MAX;
			default: return near_offset(r);
		endcase
	endfunction

	function automatic scan_item_t surface_write(input int slot, input logic end_mark,
			input logic [3:0] skind, input logic fa, input logic fb,
			input logic [CRD_W-1:0] x0, y0, zt, zb, x1, y1);
		scan_item_t it;
		it.kind = KIND_WRITE;
		it.data = '0;
		it.data.slot = slot[SLOT_W-1:0];
		it.data.end_mark = end_mark;
		it.data.surface_kind = skind;
		it.data.flag_a = fa;
		it.data.flag_b = fb;
		it.data.coord_a = x0;
		it.data.coord_b = y0;
		it.data.coord_c = zt;
		it.data.coord_d = zb;
		it.data.coord_e = x1;
		it.data.coord_f = y1;
		return it;
	endfunction

	function automatic scan_item_t position_query(input int slot,
			input logic [CRD_W-1:0] px, py, pz, limit);
		scan_item_t it;
		logic [3:0] skind;
		skind = 4'($urandom_range(0, 15));
		it = surface_write(slot, 1'($urandom_range(0, 1)), skind, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), px, py, pz, $urandom(), limit, $urandom());
		it.kind = KIND_QUERY;
		return it;
	endfunction

	task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CRD_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || s_tvalid || expected_clear.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_surface_run(inout int count);
		int start;
		int len;
		logic [3:0] skind;
		logic [CRD_W-1:0] x0, y0, zt;
		logic [CRD_W-1:0] limit;
		start = $urandom_range(0, TABLE_DEPTH - 1);
		len = $urandom_range(1, 8);
		if (start + len > TABLE_DEPTH)
			len = TABLE_DEPTH - start;
		x0 = pick_coord(48);
		for (int i = 0; i < len; i++) begin
			skind = ($urandom_range(0, 3) != 0) ? SURF_TYPE_TESTED : 4'($urandom_range(0, 15));
			y0 = pick_coord(48);
			zt = near_offset(40);
			pending_items.push_back(surface_write(start + i, 1'b0, skind,
				$urandom_range(0, 3) == 0, $urandom_range(0, 3) != 0, x0, y0, zt,
				zt - $urandom_range(0, 60), x0 + $urandom_range(0, 64),
				y0 + $urandom_range(0, 64)));
			x0 = x0 + $urandom_range(0, 12);
			count++;
		end
		if (start + len < TABLE_DEPTH && $urandom_range(0, 7) != 0) begin
			skind = 4'($urandom_range(0, 15));
			pending_items.push_back(surface_write(start + len, 1'b1, skind,
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), near_offset(48),
				near_offset(48), near_offset(40), near_offset(40), near_offset(48),
				near_offset(48)));
			count++;
		end
		repeat ($urandom_range(1, 4)) begin
			limit = $urandom_range(0, 1) ? CRD_MAX : pick_coord(64);
			pending_items.push_back(position_query(
				$urandom_range(0, 1) ? start : start + $urandom_range(0, len - 1),
				pick_coord(32), pick_coord(32), pick_coord(40), limit));
			count++;
		end
	endtask

	task automatic add_noise(inout int count);
		logic [3:0] skind;
		skind = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 1))
			pending_items.push_back(surface_write($urandom_range(0, TABLE_DEPTH - 1),
				1'($urandom_range(0, 1)), skind, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)),
				$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()));
		else
			pending_items.push_back(position_query($urandom_range(0, TABLE_DEPTH - 1),
				$urandom(), $urandom(), $urandom(), $urandom()));
		count++;
	endtask

	task automatic set_moderate_box();
		set_register(REG_BOX_MIN_X, -$urandom_range(0, 16));
		set_register(REG_BOX_MAX_X, $urandom_range(0, 16));
		set_register(REG_BOX_MIN_Y, -$urandom_range(0, 16));
		set_register(REG_BOX_MAX_Y, $urandom_range(0, 16));
		set_register(REG_VERT_EXT, $urandom_range(0, 32));
	endtask

	always @(negedge clk) begin : driver
		scan_item_t it;
		if (!s_tvalid || in_taken) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() != 0 && !calm && $urandom_range(0, 4) == 0) begin
				gap_left <= $urandom_range(0, 2);
				s_tvalid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				it = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= it.kind;
				s_tdata <= it.data;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : monitor
		in_data_t d;
		logic want;
		in_taken <= s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_clear.size() == 0) begin
				report_mismatch($sformatf("result %0d: clear %0b with no query pending",
					results_seen, m_tdata[0]));
			end else begin
				want = expected_clear.pop_front();
				if (m_tdata[0] !== want)
					report_mismatch($sformatf("result %0d: clear %b, predicted %0b",
						results_seen, m_tdata[0], want));
			end
		end
		if (arst_n && cfg_we) begin
			case (cfg_index)
				REG_PRESENT: present_cfg = cfg_data[0];
				REG_BOX_MIN_X: box_min_x_cfg = cfg_data;
				REG_BOX_MAX_X: box_max_x_cfg = cfg_data;
				REG_BOX_MIN_Y: box_min_y_cfg = cfg_data;
				REG_BOX_MAX_Y: box_max_y_cfg = cfg_data;
				REG_VERT_EXT: vert_ext_cfg = cfg_data;
				default: ;
			endcase
		end
		if (arst_n && s_tvalid && s_tready) begin
			d = s_tdata;
			if (s_tuser == KIND_WRITE) begin
				surface_table[d.slot].end_mark = d.end_mark;
				surface_table[d.slot].surface_kind = d.surface_kind;
				surface_table[d.slot].flag_a = d.flag_a;
				surface_table[d.slot].flag_b = d.flag_b;
				surface_table[d.slot].min_x = d.coord_a;
				surface_table[d.slot].min_y = d.coord_b;
				surface_table[d.slot].z_top = d.coord_c;
				surface_table[d.slot].z_bottom = d.coord_d;
				surface_table[d.slot].max_x = d.coord_e;
				surface_table[d.slot].max_y = d.coord_f;
			end else begin
				expected_clear.push_back(predict_clear(d.slot, d.coord_a, d.coord_b,
					d.coord_c, d.coord_e));
			end
		end
	end

	initial begin : stimulus
		int n;
		logic [3:0] skind;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = KIND_WRITE;
		s_tdata = '0;
		m_tready = 1'b1;
		cfg_we = 1'b0;
		cfg_index = REG_PRESENT;
		cfg_data = '0;
		present_cfg = 1'b0;
		box_min_x_cfg = '0;
		box_max_x_cfg = '0;
		box_min_y_cfg = '0;
		box_max_y_cfg = '0;
		vert_ext_cfg = '0;
		error_count = 0;
		results_seen = 0;
		gap_left = 0;
		stall_left = 0;
		in_taken = 1'b0;
		calm = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every entry written once, terminated, so no scan ever reads an unwritten entry
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			skind = 4'($urandom_range(0, 15));
			pending_items.push_back(surface_write(i, 1'b1, skind, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom()));
		end
		// no surface list: always clear
		pending_items.push_back(position_query(0, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX));
		pending_items.push_back(position_query(TABLE_DEPTH - 1, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MIN));
		wait_drained();
		repeat (20) @(negedge clk);

		set_register(REG_PRESENT, 32'd1);
		set_register(REG_BOX_MIN_X, -32'sd8);
		set_register(REG_BOX_MAX_X, 32'sd8);
		set_register(REG_BOX_MIN_Y, -32'sd8);
		set_register(REG_BOX_MAX_Y, 32'sd8);
		set_register(REG_VERT_EXT, 32'sd16);
		pending_items.push_back(surface_write(10, 1'b0, SURF_TYPE_TESTED, 1'b0, 1'b1,
			-20, -20, 10, -10, 20, 20));
		pending_items.push_back(surface_write(11, 1'b0, 4'd5, 1'b0, 1'b1,
			-20, -20, 10, -10, 20, 20));
		pending_items.push_back(surface_write(12, 1'b0, SURF_TYPE_TESTED, 1'b1, 1'b1,
			-20, -20, 10, -10, 20, 20));
		pending_items.push_back(surface_write(13, 1'b0, SURF_TYPE_TESTED, 1'b0, 1'b0,
			-20, -20, 10, -10, 20, 20));
		pending_items.push_back(surface_write(14, 1'b0, SURF_TYPE_TESTED, 1'b0, 1'b1,
			-20, -20, -10, -30, 20, 20));
		pending_items.push_back(surface_write(15, 1'b0, SURF_TYPE_TESTED, 1'b0, 1'b1,
			5, -4, 10, -10, 30, 4));
		pending_items.push_back(surface_write(16, 1'b1, SURF_TYPE_TESTED, 1'b0, 1'b1,
			-20, -20, 10, -10, 20, 20));
		pending_items.push_back(surface_write(20, 1'b0, SURF_TYPE_TESTED, 1'b0, 1'b1,
			-4, 5, 10, -10, 4, 30));
		pending_items.push_back(surface_write(21, 1'b1, 4'd0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(surface_write(TABLE_DEPTH - 1, 1'b0, 4'd0, 1'b0, 1'b0,
			0, 0, 0, 0, 0, 0));
		// containment, x edge with y span, scan limit, miss, end mark, y edge with x span,
		// table end without end mark
		pending_items.push_back(position_query(10, 0, 0, 0, CRD_MAX));
		pending_items.push_back(position_query(11, 0, 0, 0, CRD_MAX));
		pending_items.push_back(position_query(11, 0, 0, 0, 5));
		pending_items.push_back(position_query(11, 1000, 0, 0, CRD_MAX));
		pending_items.push_back(position_query(16, 0, 0, 0, CRD_MAX));
		pending_items.push_back(position_query(20, 0, 0, 0, CRD_MAX));
		pending_items.push_back(position_query(TABLE_DEPTH - 1, 0, 0, 0, CRD_MAX));

		for (int phase = 0; phase < 5; phase++) begin
			wait_drained();
			repeat (20) @(negedge clk);
			case (phase)
				0: set_moderate_box();
				1: begin
					set_register(REG_BOX_MIN_X, CRD_MIN);
					set_register(REG_BOX_MAX_X, CRD_MAX);
					set_register(REG_BOX_MIN_Y, CRD_MIN);
					set_register(REG_BOX_MAX_Y, CRD_MAX);
					set_register(REG_VERT_EXT, CRD_MAX);
				end
				2: begin
					set_register(REG_PRESENT, 32'hffff_fffe);
					set_register(REG_SPARE_LO, $urandom());
					set_register(REG_SPARE_HI, $urandom());
					set_moderate_box();
				end
				3: begin
					set_register(REG_PRESENT, 32'hffff_ffff);
					set_register(REG_BOX_MIN_X, 32'sd8);
					set_register(REG_BOX_MAX_X, -32'sd8);
					set_register(REG_BOX_MIN_Y, 32'sd0);
					set_register(REG_BOX_MAX_Y, 32'sd0);
					set_register(REG_VERT_EXT, CRD_MIN);
				end
				default: begin
					set_moderate_box();
					set_register(REG_VERT_EXT, 32'sd0);
					calm = 1'b1;
				end
			endcase
			n = 0;
			while (n < 25) begin
				if ($urandom_range(0, 4) == 0)
					add_noise(n);
				else
					add_surface_run(n);
			end
		end

		wait_drained();
		repeat (30) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
